// File: rtl/core/rfid_ascii_frame_check_and_match_defines.svh
// Assertion macros for the RFID frame checker.
// Included by the top level; needs no package.
`ifndef RFID_ASCII_FRAME_CHECK_AND_MATCH_DEFINES_SVH
`define RFID_ASCII_FRAME_CHECK_AND_MATCH_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define RAFCM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rafcm: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define RAFCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rafcm: next-cycle check failed");

`endif

// File: rtl/core/rafcm_pkg.sv
// Shared types, constants and helper functions of the RFID frame checker.
// No dependencies; imported by every module of the block.
package rafcm_pkg;

   localparam int TAG_DIGITS  = 10;
   localparam int FRAME_CHARS = TAG_DIGITS + 2;
   localparam int POS_W       = $clog2(FRAME_CHARS);
   localparam int TAG_W       = 40;
   localparam int TAG_COUNT   = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int EXT_W       = (TAG_DIGITS * 4 > TAG_W) ? TAG_DIGITS * 4 : TAG_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SUPERVISOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STUDENT_1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STUDENT_2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STUDENT_3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STUDENT_4  = 3'd4;

   localparam logic [TAG_W-1:0] SUPERVISOR_RESET = 40'h120088F349;
   localparam logic [TAG_W-1:0] STUDENT_1_RESET  = 40'h290091318C;
   localparam logic [TAG_W-1:0] STUDENT_2_RESET  = 40'h290091114B;
   localparam logic [TAG_W-1:0] STUDENT_3_RESET  = 40'h2900911BE7;
   localparam logic [TAG_W-1:0] STUDENT_4_RESET  = 40'h2900913990;

   localparam logic [7:0] LETTER_LIMIT  = 8'd64;
   localparam logic [7:0] LETTER_OFFSET = 8'd55;
   localparam logic [7:0] DIGIT_OFFSET  = 8'd48;

   localparam logic [POS_W-1:0] POS_FIRST_CHECK = POS_W'(TAG_DIGITS);
   localparam logic [POS_W-1:0] POS_LAST        = POS_W'(FRAME_CHARS - 1);

   typedef logic [TAG_COUNT-1:0][TAG_W-1:0] tag_array_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last;
      logic             checksum_ok;
      logic             supervisor_match;
      logic [2:0]       student_number;
   } acc_status_type;

   function automatic logic [7:0] char_value(input logic [7:0] c);
      return (c > LETTER_LIMIT) ? c - LETTER_OFFSET : c - DIGIT_OFFSET;
   endfunction

   // Nibble of a tag for the given digit position; digits above the tag read as zero.
   function automatic logic [3:0] tag_nibble(input logic [TAG_W-1:0] tag,
                                             input logic [POS_W-1:0] pos);
      logic [EXT_W-1:0] ext;
      logic [POS_W-1:0] idx;
      ext = EXT_W'(tag);
      idx = POS_W'(TAG_DIGITS - 1) - pos;
      return ext[{idx, 2'b00} +: 4];
   endfunction

endpackage

// File: rtl/core/rafcm_csr.sv
// Tag registers of the RFID frame checker, written through the CSR port.
// Depends on rafcm_pkg.
module rafcm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [rafcm_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [rafcm_pkg::TAG_W-1:0]     wr_data,
   output rafcm_pkg::tag_array_type        tags
);
   import rafcm_pkg::*;

   tag_array_type tags_ff;
   tag_array_type tags_in;

   always_comb begin
      tags_in = tags_ff;
      if (wr_en) begin
         case (wr_index)
            REG_SUPERVISOR: tags_in[0] = wr_data;
            REG_STUDENT_1:  tags_in[1] = wr_data;
            REG_STUDENT_2:  tags_in[2] = wr_data;
            REG_STUDENT_3:  tags_in[3] = wr_data;
            REG_STUDENT_4:  tags_in[4] = wr_data;
            default:        tags_in = tags_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tags_ff[0] <= SUPERVISOR_RESET;
         tags_ff[1] <= STUDENT_1_RESET;
         tags_ff[2] <= STUDENT_2_RESET;
         tags_ff[3] <= STUDENT_3_RESET;
         tags_ff[4] <= STUDENT_4_RESET;
      end else begin
         tags_ff <= tags_in;
      end
   end

   assign tags = tags_ff;

endmodule

// File: rtl/core/rafcm_digit_cmp.sv
// Character decode and per-tag digit comparison for one frame character.
// Depends on rafcm_pkg.
module rafcm_digit_cmp (
   input  logic [7:0]                          ascii_char,
   input  logic [rafcm_pkg::POS_W-1:0]         position,
   input  rafcm_pkg::tag_array_type            tags,
   output logic [7:0]                          value,
   output logic [rafcm_pkg::TAG_COUNT-1:0]     mismatch
);
   import rafcm_pkg::*;

   assign value = char_value(ascii_char);

   always_comb begin
      for (int k = 0; k < TAG_COUNT; k++) begin
         mismatch[k] = (value != {4'd0, tag_nibble(tags[k], position)});
      end
   end

endmodule

// File: rtl/core/rafcm_frame_acc.sv
// Frame state: position, XOR check sums and match flags, plus end-of-frame verdict.
// Depends on rafcm_pkg.
module rafcm_frame_acc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [7:0]                          value,
   input  logic [rafcm_pkg::TAG_COUNT-1:0]     mismatch,
   output rafcm_pkg::acc_status_type           status
);
   import rafcm_pkg::*;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [7:0]           even_xor_ff, even_xor_in;
   logic [7:0]           odd_xor_ff, odd_xor_in;
   logic [TAG_COUNT-1:0] flags_ff, flags_in;
   logic                 first_ok_ff, first_ok_in;
   logic                 sum_ok;

   always_comb begin
      pos_in      = pos_ff;
      even_xor_in = even_xor_ff;
      odd_xor_in  = odd_xor_ff;
      flags_in    = flags_ff;
      first_ok_in = first_ok_ff;
      if (step) begin
         if (pos_ff < POS_FIRST_CHECK) begin
            if (pos_ff[0]) begin
               odd_xor_in = odd_xor_ff ^ value;
            end else begin
               even_xor_in = even_xor_ff ^ value;
            end
            flags_in = flags_ff & ~mismatch;
            pos_in   = pos_ff + 1'b1;
         end else if (pos_ff == POS_FIRST_CHECK) begin
            first_ok_in = (even_xor_ff == value);
            pos_in      = pos_ff + 1'b1;
         end else begin
            // close the frame and start over
            pos_in      = '0;
            even_xor_in = '0;
            odd_xor_in  = '0;
            flags_in    = '1;
            first_ok_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         even_xor_ff <= '0;
         odd_xor_ff  <= '0;
         flags_ff    <= '1;
         first_ok_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         even_xor_ff <= even_xor_in;
         odd_xor_ff  <= odd_xor_in;
         flags_ff    <= flags_in;
         first_ok_ff <= first_ok_in;
      end
   end

   assign sum_ok = first_ok_ff && (odd_xor_ff == value);

   always_comb begin
      status.position         = pos_ff;
      status.last             = (pos_ff >= POS_LAST);
      status.checksum_ok      = sum_ok;
      status.supervisor_match = sum_ok && flags_ff[0];
      if (!sum_ok) begin
         status.student_number = 3'd0;
      end else if (flags_ff[1]) begin
         status.student_number = 3'd1;
      end else if (flags_ff[2]) begin
         status.student_number = 3'd2;
      end else if (flags_ff[3]) begin
         status.student_number = 3'd3;
      end else if (flags_ff[4]) begin
         status.student_number = 3'd4;
      end else begin
         status.student_number = 3'd0;
      end
   end

endmodule

// File: rtl/core/rfid_ascii_frame_check_and_match.sv
// RFID reader frame checker: takes twelve ASCII characters per frame (ten hex tag
// digits, two XOR check digits), one request per cycle with no bubbles. A
// request is captured in an input register and then processed by the frame state
// logic; on the twelfth character a response carrying checksum validity,
// supervisor match and first matching student (1 to 4) is loaded into the
// response register when the frame state logic takes that character.
// Sustained rate is one character per cycle; only a held response on the last
// character stalls requests. Tag registers are written through the CSR port,
// always ready; the user must write them while idle, as the block does not check it.
module rfid_ascii_frame_check_and_match (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_ascii_char,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_checksum_ok,
   output logic                            rsp_supervisor_match,
   output logic [2:0]                      rsp_student_number,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rafcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rafcm_pkg::TAG_W-1:0]     csr_data
);
   import rafcm_pkg::*;

`include "rfid_ascii_frame_check_and_match_defines.svh"

   tag_array_type        tags;
   acc_status_type       status;
   logic [7:0]           value;
   logic [TAG_COUNT-1:0] mismatch;

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       out_valid_ff;
   logic       out_ok_ff;
   logic       out_sup_ff;
   logic [2:0] out_stu_ff;

   logic out_free;
   logic step;
   logic req_accept;

   assign csr_ready = 1'b1;

   rafcm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .tags     (tags)
   );

   rafcm_digit_cmp u_digit_cmp (
      .ascii_char (in_char_ff),
      .position   (status.position),
      .tags       (tags),
      .value      (value),
      .mismatch   (mismatch)
   );

   rafcm_frame_acc u_frame_acc (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .value    (value),
      .mismatch (mismatch),
      .status   (status)
   );

   // Only the closing character needs room in the response register.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign step       = in_valid_ff && (!status.last || out_free);
   assign req_stall  = in_valid_ff && !step;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (step && status.last) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_ascii_char;
      end
      if (step && status.last) begin
         out_ok_ff  <= status.checksum_ok;
         out_sup_ff <= status.supervisor_match;
         out_stu_ff <= status.student_number;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_checksum_ok      = out_ok_ff;
   assign rsp_supervisor_match = out_sup_ff;
   assign rsp_student_number   = out_stu_ff;

   `RAFCM_ASSERT_NOW(a_bad_sum_no_match, clock, reset, rsp_valid && !rsp_checksum_ok,
                     !rsp_supervisor_match && (rsp_student_number == 3'd0))
   `RAFCM_ASSERT_NOW(a_student_range, clock, reset, rsp_valid, rsp_student_number <= 3'd4)
   `RAFCM_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall,
                     in_valid_ff && status.last && rsp_valid && rsp_stall)
   `RAFCM_ASSERT_NEXT(a_close_gives_rsp, clock, reset, step && status.last,
                      rsp_valid && (status.position == '0))

endmodule

// File: tb/sv/rfid_ascii_frame_check_and_match_tb.sv
// Testbench for the RFID ASCII frame checker: drives reader frames and tag writes,
// predicts each frame verdict and checks it against the response channel.
// Depends on rafcm_pkg and the rfid_ascii_frame_check_and_match top level.
`timescale 1ns / 1ps

module rfid_ascii_frame_check_and_match_tb;
   import rafcm_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES    = 4;

   typedef struct packed {
      logic       checksum_ok;
      logic       supervisor_match;
      logic [2:0] student_number;
   } verdict_type;

   typedef enum int {FR_CLEAN, FR_BAD_FIRST, FR_BAD_SECOND, FR_NOISE} frame_style_type;

   // Tracks frame state, tag registers and the verdicts still owed by the block.
   class frame_verdict_board_type;
      logic [TAG_W-1:0] tags [TAG_COUNT];
      int unsigned      position;
      logic [7:0]       even_xor;
      logic [7:0]       odd_xor;
      logic [4:0]       still_matching;
      bit               first_check;
      verdict_type      verdicts_due [$];
      int unsigned      errors;
      int unsigned      characters;
      int unsigned      frames;
      int unsigned      good_frames;
      int unsigned      supervisor_hits;
      int unsigned      student_hits;

      function new();
         tags[REG_SUPERVISOR] = SUPERVISOR_RESET;
         tags[REG_STUDENT_1]  = STUDENT_1_RESET;
         tags[REG_STUDENT_2]  = STUDENT_2_RESET;
         tags[REG_STUDENT_3]  = STUDENT_3_RESET;
         tags[REG_STUDENT_4]  = STUDENT_4_RESET;
         restart_frame();
      endfunction

      function void restart_frame();
         position       = 0;
         even_xor       = 8'h00;
         odd_xor        = 8'h00;
         still_matching = 5'b11111;
         first_check    = 1'b0;
      endfunction

      function logic [7:0] char_value(logic [7:0] c);
         return (c > LETTER_LIMIT) ? 8'(c - LETTER_OFFSET) : 8'(c - DIGIT_OFFSET);
      endfunction

      function void load_tag(logic [CSR_IDX_W-1:0] idx, logic [TAG_W-1:0] value);
         // writes beyond the last student register are dropped
         if (idx <= REG_STUDENT_4)
            tags[idx] = value;
      endfunction

      function void note_char(logic [7:0] c);
         logic [7:0]  v;
         logic [3:0]  nib;
         verdict_type due;
         v = char_value(c);
         characters++;
         if (position < TAG_DIGITS) begin
            if (position % 2 == 0)
               even_xor ^= v;
            else
               odd_xor ^= v;
            for (int k = 0; k < TAG_COUNT; k++) begin
               nib = tags[k][4 * (TAG_DIGITS - 1 - position) +: 4];
               if (v != {4'h0, nib})
                  still_matching[k] = 1'b0;
            end
            position++;
         end else if (position == TAG_DIGITS) begin
            first_check = (even_xor == v);
            position++;
         end else begin
            due.checksum_ok      = first_check && (odd_xor == v);
            due.supervisor_match = 1'b0;
            due.student_number   = 3'd0;
            if (due.checksum_ok) begin
               due.supervisor_match = still_matching[0];
               // lowest numbered student wins
               for (int k = TAG_COUNT - 1; k >= 1; k--)
                  if (still_matching[k])
                     due.student_number = 3'(k);
            end
            frames++;
            good_frames     += due.checksum_ok;
            supervisor_hits += due.supervisor_match;
            student_hits    += (due.student_number != 3'd0);
            verdicts_due.push_back(due);
            restart_frame();
         end
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= 10)
               $display("frame verdict %s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("response with no frame outstanding: %0d %0d %0d",
                        got.checksum_ok, got.supervisor_match, got.student_number);
         end else begin
            want = verdicts_due.pop_front();
            compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
            compare_field("supervisor_match", want.supervisor_match,
                          got.supervisor_match);
            compare_field("student_number", want.student_number, got.student_number);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_ascii_char;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_checksum_ok;
   logic                 rsp_supervisor_match;
   logic [2:0]           rsp_student_number;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TAG_W-1:0]     csr_data;

   frame_verdict_board_type board;
   bit                      idling        = 1'b1;
   bit                      long_hold_due = 1'b0;
   int unsigned             cycle_count   = 0;
   int unsigned             settings_used = 1;

   rfid_ascii_frame_check_and_match uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ascii_char       (req_ascii_char),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_checksum_ok      (rsp_checksum_ok),
      .rsp_supervisor_match (rsp_supervisor_match),
      .rsp_student_number   (rsp_student_number),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rfid_ascii_frame_check_and_match_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict('{rsp_checksum_ok, rsp_supervisor_match, rsp_student_number});
   end

   // Receiver side: short random holds, or one long hold when asked.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [7:0] char_for_value(logic [7:0] x);
      logic [7:0] hits [$];
      for (int c = 0; c < 256; c++)
         if (board.char_value(8'(c)) == x)
            hits.push_back(8'(c));
      if (hits.size() == 0)
         return x;
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   function automatic logic [TAG_W-1:0] random_tag();
      return {8'($urandom()), 32'($urandom())};
   endfunction

   task automatic send_char(input logic [7:0] c);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_ascii_char <= c;
      do
         @(posedge clock);
      while (req_stall);
      board.note_char(c);
   endtask

   task automatic send_frame(input logic [TAG_W-1:0] tag, input frame_style_type style);
      logic [7:0] chars [FRAME_CHARS];
      logic [7:0] even_x;
      logic [7:0] odd_x;
      logic [7:0] v;
      even_x = 8'h00;
      odd_x  = 8'h00;
      for (int i = 0; i < TAG_DIGITS; i++) begin
         if (style == FR_NOISE && $urandom_range(0, 2) == 0)
            chars[i] = 8'($urandom());
         else
            chars[i] = char_for_value({4'h0, tag[4 * (TAG_DIGITS - 1 - i) +: 4]});
         v = board.char_value(chars[i]);
         if (i % 2 == 0)
            even_x ^= v;
         else
            odd_x ^= v;
      end
      chars[TAG_DIGITS]     = char_for_value(even_x);
      chars[TAG_DIGITS + 1] = char_for_value(odd_x);
      case (style)
         FR_BAD_FIRST: begin
            chars[TAG_DIGITS] ^= 8'(1 << $urandom_range(0, 7));
         end
         FR_BAD_SECOND: begin
            chars[TAG_DIGITS + 1] ^= 8'(1 << $urandom_range(0, 7));
         end
         FR_NOISE: begin
            if ($urandom_range(0, 1) == 0)
               chars[TAG_DIGITS + $urandom_range(0, 1)] = 8'($urandom());
         end
         default: begin
         end
      endcase
      for (int i = 0; i < FRAME_CHARS; i++)
         send_char(chars[i]);
   endtask

   task automatic send_random_frame();
      logic [TAG_W-1:0] tag;
      int               pick;
      int               style_pick;
      frame_style_type  style;
      pick       = $urandom_range(0, 9);
      style_pick = $urandom_range(0, 19);
      if (pick < 8)
         tag = board.tags[$urandom_range(0, TAG_COUNT - 1)];
      else
         tag = random_tag();
      // near miss: one digit of a known tag replaced by a random value
      if (pick == 6 || pick == 7)
         tag[4 * $urandom_range(0, TAG_DIGITS - 1) +: 4] = 4'($urandom());
      if (style_pick < 14)
         style = FR_CLEAN;
      else if (style_pick < 16)
         style = FR_BAD_FIRST;
      else if (style_pick < 18)
         style = FR_BAD_SECOND;
      else
         style = FR_NOISE;
      send_frame(tag, style);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (board.verdicts_due.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_tag(input logic [CSR_IDX_W-1:0] idx, input logic [TAG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      board.load_tag(idx, value);
   endtask

   task automatic apply_setting(input logic [TAG_W-1:0] sup, input logic [TAG_W-1:0] s1,
                                input logic [TAG_W-1:0] s2, input logic [TAG_W-1:0] s3,
                                input logic [TAG_W-1:0] s4);
      pause_until_drained();
      // a last-character request may still be in flight behind the final response
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_tag(REG_SUPERVISOR, sup);
      write_tag(REG_STUDENT_1, s1);
      write_tag(REG_STUDENT_2, s2);
      write_tag(REG_STUDENT_3, s3);
      write_tag(REG_STUDENT_4, s4);
      write_tag(REG_STUDENT_4 + CSR_IDX_W'($urandom_range(1, 3)), random_tag());
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   initial begin
      logic [7:0]       odd_frame [FRAME_CHARS];
      logic [TAG_W-1:0] shared;
      logic [TAG_W-1:0] twin;
      board          = new();
      odd_frame      = '{8'h00, 8'hFF, "a", "G", "@", ":", "?", "0", "9", "F", "z", 8'h80};
      req_valid      <= 1'b0;
      req_ascii_char <= 8'h00;
      csr_valid      <= 1'b0;
      csr_index      <= REG_SUPERVISOR;
      csr_data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset tags: a clean supervisor frame, then raw bytes with a broken checksum
      send_frame(SUPERVISOR_RESET, FR_CLEAN);
      for (int i = 0; i < FRAME_CHARS; i++)
         send_char(odd_frame[i]);
      repeat (8) send_random_frame();

      // extreme tag values, duplicated so that several cards hit at once
      apply_setting('0, '1, '0, '1, '0);
      repeat (6) send_random_frame();

      // duplicate students and supervisor; one long receiver hold
      shared = random_tag();
      twin   = random_tag();
      apply_setting(shared, twin, random_tag(), twin, shared);
      repeat (2) send_random_frame();
      long_hold_due = 1'b1;
      repeat (4) send_random_frame();
      repeat (2) send_random_frame();

      // independent tags; sender waits for every verdict midway
      apply_setting(random_tag(), random_tag(), random_tag(), random_tag(), random_tag());
      repeat (4) send_random_frame();
      pause_until_drained();
      repeat (4) send_random_frame();

      // back to the power-on cards, both sides running flat out
      apply_setting(SUPERVISOR_RESET, STUDENT_1_RESET, STUDENT_2_RESET,
                    STUDENT_3_RESET, STUDENT_4_RESET);
      idling = 1'b0;
      repeat (10) send_random_frame();

      pause_until_drained();
      repeat (8) @(posedge clock);
      $display("%0d characters in %0d frames over %0d tag settings", board.characters,
               board.frames, settings_used);
      $display("%0d good checksums, %0d supervisor hits, %0d student hits",
               board.good_frames, board.supervisor_hits, board.student_hits);
      if (board.errors == 0 && board.verdicts_due.size() == 0)
         $display("rfid_ascii_frame_check_and_match_tb: clean");
      else
         $display("rfid_ascii_frame_check_and_match_tb: errors");
      $finish;
   end

endmodule
